// ===== hdl/assert_macros.svh =====
// assertion helpers used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pvcf_pkg.sv =====
// ----------------------------------------------------------------------------
// pvcf_pkg
// Shared types and constants for the per-value occurrence cap filter.
// ----------------------------------------------------------------------------
package pvcf_pkg;

    localparam int VAL_W = 32;
    localparam int CNT_W = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic upd;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic done;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hdl/per_value_occurrence_cap_filter_core.sv =====
// ----------------------------------------------------------------------------
// per_value_occurrence_cap_filter_core
// Passes list elements on while fewer than max_count equal values were kept, and always when the table is full.
// ----------------------------------------------------------------------------
// Each input beat is one list element; one result beat comes back for it with
// the value, a kept flag, the end-of-list echo and a table-full flag. Distinct
// values of the current list live in a single-port table that is searched one
// entry per cycle from the oldest entry, so a new value is read against every
// entry, while the first element of a list meets an empty table and skips the
// search. The search stops at the first match. The table is emptied by
// resetting its fill count after the beat marked last, so no clearing pass is
// needed. The result sits in an output register, so the next element is taken
// while a result still waits; the update of that next element waits for the
// register to be free.
// ----------------------------------------------------------------------------
module per_value_occurrence_cap_filter_core #(
    parameter int DISTINCT_KEYS = 64,
    parameter int VALUE_BITS    = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [pvcf_pkg::CNT_W-1:0]        i_cfg_wr_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [pvcf_pkg::VAL_W-1:0] i_item_value,
    input  logic                              i_last_item,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [pvcf_pkg::VAL_W-1:0] o_out_value,
    output logic                              o_kept,
    output logic                              o_out_last,
    output logic                              o_table_full
);
    import pvcf_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    pvcf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    pvcf_datapath #(
        .DISTINCT_KEYS (DISTINCT_KEYS),
        .VALUE_BITS    (VALUE_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_item_value  (i_item_value),
        .i_last_item   (i_last_item),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_value   (o_out_value),
        .o_kept        (o_kept),
        .o_out_last    (o_out_last),
        .o_table_full  (o_table_full)
    );

endmodule

// ===== hdl/pvcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// pvcf_ctrl
// Sequencer: accept a beat, scan the table unless it is empty, update and hand over the result.
// ----------------------------------------------------------------------------
module pvcf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  pvcf_pkg::t_dp_status i_status,
    output pvcf_pkg::t_dp_cmd    o_cmd
);
    import pvcf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    // an empty table has nothing to search
                    n_state = i_status.empty ? ST_UPD : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.done) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall    = 1'b1;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_UPD: begin
                o_cmd.upd = i_status.out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hdl/pvcf_datapath.sv =====
// ----------------------------------------------------------------------------
// pvcf_datapath
// Key/count table, linear key search, count update and output register.
// ----------------------------------------------------------------------------
module pvcf_datapath #(
    parameter int DISTINCT_KEYS = 64,
    parameter int VALUE_BITS    = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [pvcf_pkg::CNT_W-1:0]          i_cfg_wr_data,
    input  logic signed [pvcf_pkg::VAL_W-1:0]   i_item_value,
    input  logic                                i_last_item,
    input  pvcf_pkg::t_dp_cmd                   i_cmd,
    output pvcf_pkg::t_dp_status                o_status,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic signed [pvcf_pkg::VAL_W-1:0]   o_out_value,
    output logic                                o_kept,
    output logic                                o_out_last,
    output logic                                o_table_full
);
    import pvcf_pkg::*;

    localparam int KEY_W = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
    localparam int IDX_W = (DISTINCT_KEYS > 1) ? $clog2(DISTINCT_KEYS) : 1;
    localparam int USE_W = $clog2(DISTINCT_KEYS + 1);
    localparam int ENT_W = CNT_W + KEY_W;
    localparam logic [USE_W-1:0] USE_MAX = USE_W'(DISTINCT_KEYS);

    // table word: count above key
    logic [ENT_W-1:0] mem [DISTINCT_KEYS];

    logic [CNT_W-1:0] r_max_count;
    logic signed [VAL_W-1:0] r_value;
    logic [KEY_W-1:0] r_key;
    logic             r_last;
    logic [USE_W-1:0] r_used;
    logic [USE_W-1:0] n_used;
    logic [USE_W-1:0] r_addr;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_pend;
    logic [ENT_W-1:0] r_rd_data;
    logic             r_found;
    logic [IDX_W-1:0] r_hit_idx;
    logic [CNT_W-1:0] r_hit_cnt;

    logic             r_out_valid;
    logic signed [VAL_W-1:0] r_out_value;
    logic             r_out_kept;
    logic             r_out_last;
    logic             r_out_full;

    logic             w_issue;
    logic [KEY_W-1:0] w_rd_key;
    logic [CNT_W-1:0] w_rd_cnt;
    logic             w_match;
    logic             w_last_ent;
    logic             w_room;
    logic             w_kept;
    logic             w_full;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_idx;
    logic [CNT_W-1:0] w_wr_cnt;
    logic             w_take;

    assign w_issue    = i_cmd.scan && (r_addr < r_used);
    assign w_rd_key   = r_rd_data[KEY_W-1:0];
    assign w_rd_cnt   = r_rd_data[ENT_W-1:KEY_W];
    assign w_match    = r_rd_pend && (w_rd_key == r_key);
    assign w_last_ent = r_rd_pend && (USE_W'(r_rd_idx) == (r_used - USE_W'(1)));
    assign w_room     = r_used < USE_MAX;
    assign w_take     = r_out_valid && !i_stall;

    assign o_status.empty    = (r_used == '0);
    assign o_status.done     = w_match || w_last_ent;
    assign o_status.out_free = !r_out_valid || !i_stall;

    // outcome of the search
    always_comb begin
        w_kept   = 1'b0;
        w_full   = 1'b0;
        w_wr_en  = 1'b0;
        w_wr_idx = r_hit_idx;
        w_wr_cnt = r_hit_cnt + CNT_W'(1);
        priority if (r_found) begin
            // counts stop at the limit
            w_kept  = r_hit_cnt < r_max_count;
            w_wr_en = w_kept;
        end else if (w_room) begin
            w_kept   = (r_max_count != '0);
            w_wr_en  = 1'b1;
            w_wr_idx = r_used[IDX_W-1:0];
            w_wr_cnt = w_kept ? CNT_W'(1) : '0;
        end else begin
            w_kept = 1'b1;
            w_full = 1'b1;
        end
    end

    always_comb begin
        n_used = r_used;
        if (i_cmd.upd) begin
            priority if (r_last) begin
                n_used = '0;
            end else if (!r_found && w_room) begin
                n_used = r_used + USE_W'(1);
            end else begin
                n_used = r_used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd && w_wr_en) begin
            mem[w_wr_idx] <= {w_wr_cnt, r_key};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_data <= mem[r_addr[IDX_W-1:0]];
            r_rd_idx  <= r_addr[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_count <= CNT_W'(1);
            r_used      <= '0;
            r_addr      <= '0;
            r_rd_pend   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_count <= i_cfg_wr_data;
            end
            r_used    <= n_used;
            r_rd_pend <= w_issue;
            if (i_cmd.load) begin
                r_addr  <= '0;
                r_found <= 1'b0;
            end else if (w_issue) begin
                r_addr <= r_addr + USE_W'(1);
            end
            if (i_cmd.scan && w_match) begin
                r_found <= 1'b1;
            end
            if (i_cmd.upd) begin
                r_out_valid <= 1'b1;
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_item_value;
            r_key   <= i_item_value[KEY_W-1:0];
            r_last  <= i_last_item;
        end
        if (i_cmd.scan && w_match) begin
            r_hit_idx <= r_rd_idx;
            r_hit_cnt <= w_rd_cnt;
        end
        if (i_cmd.upd) begin
            r_out_value <= r_value;
            r_out_kept  <= w_kept;
            r_out_last  <= r_last;
            r_out_full  <= w_full;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_kept       = r_out_kept;
    assign o_out_last   = r_out_last;
    assign o_table_full = r_out_full;

endmodule

// ===== hdl/pvcf_checker.sv =====
// ----------------------------------------------------------------------------
// pvcf_checker
// Port-level checks for the occurrence cap filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pvcf_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic signed [pvcf_pkg::VAL_W-1:0] o_out_value,
    input logic                              o_kept,
    input logic                              o_out_last,
    input logic                              o_table_full
);
    // a stalled result beat holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_out_value) && $stable(o_out_last), "result changed while stalled")

    // a value that found no free entry is always passed on
    `ASSERT_IMPLY(a_full_kept, i_clk, i_rst_n, o_valid && o_table_full, o_kept,
        "table_full without kept")

    // a taken beat is followed by a stall while the search and update run
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall,
        "input taken again right after a beat")

    // a fresh result only follows work on an element, while the input stalls
    `ASSERT_IMPLY(a_result_after_work, i_clk, i_rst_n, $rose(o_valid), $past(o_stall),
        "result appeared without an element in work")

endmodule

bind per_value_occurrence_cap_filter_core pvcf_checker u_checker (.*);

// ===== tb/per_value_occurrence_cap_filter_core_checker.sv =====
// ----------------------------------------------------------------------------
// per_value_occurrence_cap_filter_core_checker
// Watches both channels of the cap filter, predicts every result beat from
// its own copy of the value table and the limit, and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module per_value_occurrence_cap_filter_core_checker #(
    parameter int DISTINCT_KEYS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [pvcf_pkg::CNT_W-1:0]        i_cfg_wr_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic signed [pvcf_pkg::VAL_W-1:0] i_item_value,
    input  logic                              i_last_item,
    input  logic                              i_res_valid,
    input  logic                              i_res_stall,
    input  logic signed [pvcf_pkg::VAL_W-1:0] i_out_value,
    input  logic                              i_kept,
    input  logic                              i_out_last,
    input  logic                              i_table_full,
    output int                                o_errors,
    output int                                o_pending
);

    typedef struct packed {
        logic signed [pvcf_pkg::VAL_W-1:0] value;
        logic                              kept;
        logic                              last;
        logic                              full;
    } t_filter_beat;

    logic                              key_seen [DISTINCT_KEYS];
    logic signed [pvcf_pkg::VAL_W-1:0] key_value[DISTINCT_KEYS];
    logic [pvcf_pkg::CNT_W-1:0]        key_count[DISTINCT_KEYS];
    int                                keys_used;
    logic [pvcf_pkg::CNT_W-1:0]        copy_limit;
    t_filter_beat                      expected_beats[$];

    function automatic void forget_list();
        for (int i = 0; i < DISTINCT_KEYS; i++) begin
            key_seen[i]  = 1'b0;
            key_value[i] = '0;
            key_count[i] = '0;
        end
        keys_used = 0;
    endfunction

    function automatic t_filter_beat filter_element(logic signed [pvcf_pkg::VAL_W-1:0] v,
                                                    logic l);
        t_filter_beat r;
        bit           hit;
        r.value = v;
        r.kept  = 1'b0;
        r.last  = l;
        r.full  = 1'b0;
        hit     = 1'b0;
        for (int i = 0; i < DISTINCT_KEYS; i++) begin
            if (!hit && key_seen[i] && key_value[i] == v) begin
                hit = 1'b1;
                // saturates at the limit, also when the limit was lowered
                if (key_count[i] < copy_limit) begin
                    key_count[i] = key_count[i] + 1'b1;
                    r.kept       = 1'b1;
                end
            end
        end
        if (!hit) begin
            if (keys_used < DISTINCT_KEYS) begin
                key_seen[keys_used]  = 1'b1;
                key_value[keys_used] = v;
                key_count[keys_used] = (copy_limit != '0) ? 8'd1 : 8'd0;
                r.kept               = (copy_limit != '0);
                keys_used++;
            end else begin
                // no room: passed through untracked
                r.kept = 1'b1;
                r.full = 1'b1;
            end
        end
        if (l)
            forget_list();
        return r;
    endfunction

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        $display("%t checker: %s mismatch, expected %0h got %0h", $realtime, field, want, got);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_filter_beat want;
        if (!i_rst_n) begin
            forget_list();
            copy_limit = 8'd1;
            expected_beats.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_wr_en)
                copy_limit = i_cfg_wr_data;
            if (i_res_valid && !i_res_stall) begin
                if (expected_beats.size() == 0) begin
                    report("unexpected beat", 32'h0, i_out_value);
                end else begin
                    want = expected_beats.pop_front();
                    if (i_out_value !== want.value)
                        report("out_value", want.value, i_out_value);
                    if (i_kept !== want.kept)
                        report("kept", 32'(want.kept), 32'(i_kept));
                    if (i_out_last !== want.last)
                        report("out_last", 32'(want.last), 32'(i_out_last));
                    if (i_table_full !== want.full)
                        report("table_full", 32'(want.full), 32'(i_table_full));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_beats.push_back(filter_element(i_item_value, i_last_item));
        end
        o_pending = expected_beats.size();
    end

endmodule

// ===== tb/per_value_occurrence_cap_filter_core_tb.sv =====
// ----------------------------------------------------------------------------
// per_value_occurrence_cap_filter_core_tb
// Drives lists of values through the cap filter under several limits, with
// random gaps on the input and random stalls on the output; the checker
// predicts every result beat and the top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module per_value_occurrence_cap_filter_core_tb;

    localparam int IDLE_LIMIT   = 3000;
    localparam int RANDOM_ITEMS = 750;
    localparam int TABLE_DEPTH  = 64;

    logic                              clk         = 1'b0;
    logic                              rst_n       = 1'b0;
    logic                              cfg_wr_en   = 1'b0;
    logic [pvcf_pkg::CNT_W-1:0]        cfg_wr_data = '0;
    logic                              in_valid    = 1'b0;
    logic                              in_stall;
    logic signed [pvcf_pkg::VAL_W-1:0] item_value  = '0;
    logic                              last_item   = 1'b0;
    logic                              res_valid;
    logic                              res_stall   = 1'b0;
    logic signed [pvcf_pkg::VAL_W-1:0] out_value;
    logic                              kept;
    logic                              out_last;
    logic                              table_full;

    int   errors;
    int   pending;
    int   idle_cycles = 0;
    int   stall_left  = 0;
    logic rx_quiet    = 1'b0;
    bit   tx_quiet    = 1'b0;
    int   random_sent = 0;

    always #1 clk = ~clk;

    per_value_occurrence_cap_filter_core DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_item_value (item_value),
        .i_last_item  (last_item),
        .o_valid      (res_valid),
        .i_stall      (res_stall),
        .o_out_value  (out_value),
        .o_kept       (kept),
        .o_out_last   (out_last),
        .o_table_full (table_full)
    );

    per_value_occurrence_cap_filter_core_checker #(
        .DISTINCT_KEYS(TABLE_DEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_item_value (item_value),
        .i_last_item  (last_item),
        .i_res_valid  (res_valid),
        .i_res_stall  (res_stall),
        .i_out_value  (out_value),
        .i_kept       (kept),
        .i_out_last   (out_last),
        .i_table_full (table_full),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    // mostly none or short, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 50);
    endfunction

    function automatic logic signed [pvcf_pkg::VAL_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0;
            3: return -32'sh1;
            default: return $urandom();
        endcase
    endfunction

    // receiver stalls held for random stretches
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else begin
            res_stall  <= rx_quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
            stall_left <= gap_len();
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("per_value_occurrence_cap_filter_core_tb: done, errors");
            $finish;
        end
    end

    task automatic send_element(input logic signed [pvcf_pkg::VAL_W-1:0] v, input logic l);
        int gap;
        gap = tx_quiet ? 0 : gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        item_value <= v;
        last_item  <= l;
        do @(posedge clk); while (in_stall);
    endtask

    // called on the edge of the last accepted beat
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_limit(input logic [pvcf_pkg::CNT_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // more distinct values than the table holds, then repeats of old and new
    task automatic send_wide_list();
        logic signed [pvcf_pkg::VAL_W-1:0] base;
        int                                n;
        base = $urandom();
        n    = TABLE_DEPTH + $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_element(base + i, 1'b0);
        for (int k = 0; k < 6; k++)
            send_element(base + $urandom_range(0, n - 1), k == 5);
        random_sent += n + 6;
    endtask

    task automatic send_pool_list();
        logic signed [pvcf_pkg::VAL_W-1:0] pool[8];
        logic signed [pvcf_pkg::VAL_W-1:0] v;
        int                                pool_size;
        int                                len;
        pool_size = $urandom_range(1, 8);
        len       = $urandom_range(1, 24);
        for (int i = 0; i < pool_size; i++)
            pool[i] = rand_value();
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0)
                v = rand_value();
            else
                v = pool[$urandom_range(0, pool_size - 1)];
            send_element(v, i == len - 1);
        end
        random_sent += len;
    endtask

    initial begin
        logic [pvcf_pkg::CNT_W-1:0] limit_seq[5];
        logic [pvcf_pkg::CNT_W-1:0] lim;
        logic signed [pvcf_pkg::VAL_W-1:0] v;
        int                         phase;
        int                         lists;
        bit                         saturated_done;
        limit_seq      = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd3};
        phase          = 0;
        saturated_done = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // limit of one from reset: extremes, then second copies dropped
        send_element(32'sh8000_0000, 1'b0);
        send_element(32'sh7fff_ffff, 1'b0);
        send_element(32'sh0, 1'b0);
        send_element(-32'sh1, 1'b0);
        send_element(32'sh8000_0000, 1'b0);
        send_element(32'sh0, 1'b0);
        send_element(-32'sh1, 1'b1);
        // table forgotten after the end mark
        send_element(32'sh8000_0000, 1'b1);

        // limit lowered while a list is open
        drain();
        write_limit(8'd3);
        repeat (3) send_element(32'sd5, 1'b0);
        drain();
        write_limit(8'd1);
        send_element(32'sd5, 1'b0);
        send_element(32'sd6, 1'b0);
        send_element(32'sd6, 1'b1);

        // zero limit drops everything
        drain();
        write_limit(8'd0);
        send_element(32'sd7, 1'b0);
        send_element(32'sd7, 1'b0);
        send_element(-32'sd8, 1'b1);

        while (random_sent < RANDOM_ITEMS) begin
            if (phase < 5)
                lim = limit_seq[phase];
            else if ($urandom_range(0, 3) == 0)
                lim = 8'($urandom_range(0, 255));
            else
                lim = 8'($urandom_range(1, 4));
            drain();
            write_limit(lim);
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet <= tx_quiet;

            if (phase == 0 || phase == 1 || phase == 3)
                send_wide_list();
            if (lim == 8'd255 && !saturated_done) begin
                // count runs up to the top of its range and stays there
                v = rand_value();
                for (int i = 0; i < 258; i++)
                    send_element(v, i == 257);
                random_sent += 258;
                saturated_done = 1'b1;
            end

            lists = $urandom_range(2, 6);
            for (int i = 0; i < lists; i++)
                send_pool_list();
            phase++;
        end

        drain();
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("per_value_occurrence_cap_filter_core_tb: done, clean");
        else
            $display("per_value_occurrence_cap_filter_core_tb: done, errors");
        $finish;
    end

endmodule

// ===== per_value_occurrence_cap_filter_core.f =====
+incdir+hdl
hdl/pvcf_pkg.sv
hdl/pvcf_ctrl.sv
hdl/pvcf_datapath.sv
hdl/per_value_occurrence_cap_filter_core.sv
hdl/pvcf_checker.sv
tb/per_value_occurrence_cap_filter_core_checker.sv
tb/per_value_occurrence_cap_filter_core_tb.sv
